[hw/rtl/fes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types and constants for the function extent scanner.
// ----------------------------------------------------------------------------
package fes_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [WORD_W-1:0] RETURN_WORD_RST = 32'h4e80_0020;
  localparam logic [WORD_W-1:0] RFI_WORD_RST    = 32'h4c00_0064;
  localparam logic [WORD_W-1:0] NOP_WORD_RST    = 32'h6000_0000;

  localparam logic [WORD_W-1:0] PRIMARY_OP_MASK = 32'hfc00_0000;
  localparam logic [WORD_W-1:0] BC_OPCODE       = 32'h4000_0000;
  localparam logic [WORD_W-1:0] DISP_MASK       = 32'h0000_fffc;
  localparam logic [WORD_W-1:0] WORD_BYTES      = 32'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_WORD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RFI_WORD    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOP_WORD    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ZERO    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETURN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RFI     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RFI_NOP = 2'd3;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_SCAN,
    PHASE_AFTER_RFI
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] ret_word;
    logic [WORD_W-1:0] rfi_word;
    logic [WORD_W-1:0] nop_word;
  } words_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] bytes;
    logic [KIND_W-1:0] kind;
  } result_t;

endpackage

[hw/rtl/function_extent_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// function_extent_scanner
// Reports the byte size of a PowerPC function from its instruction stream.
//
// Input channel in_*: one instruction word per item, in address order; the
// first word of a function carries in_tuser = 1 and its address.
// Output channel out_*: one item per finished function with its byte size in
// out_tdata and the end kind in out_tuser (zero word, return, rfi, rfi+nop).
// Configuration channel cfg_*: writes the return, rfi and nop encodings;
// always ready; to be written only while the block is idle, which the block itself does not enforce.
// The item that ends a function is held in the input register, and its result
// is registered in the result register. Throughput: one item per cycle while
// results are taken, through the scan step (branch target add and max compare).
// Reset clears the scan state and loads the default encodings.
// A stalled receiver holds the result; one more item waits in the input
// register, after which in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module function_extent_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [63:0]                        in_tdata,  // instruction, base_address
  input  logic [0:0]                         in_tuser,  // first_word
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata, // function_bytes
  output logic [1:0]                         out_tuser, // end_kind
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fes_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fes_pkg::WORD_W-1:0]         cfg_data
);
  import fes_pkg::*;

  words_t            words_r, words_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0] s1_instr_r;
  logic              s1_first_r;
  logic [WORD_W-1:0] s1_base_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_bytes_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              advance;
  logic              step;
  result_t           res;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign step       = s1_valid_r && advance;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_bytes_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    words_nxt = words_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RETURN_WORD: words_nxt.ret_word = cfg_data;
        CFG_RFI_WORD:    words_nxt.rfi_word = cfg_data;
        CFG_NOP_WORD:    words_nxt.nop_word = cfg_data;
        default: begin
        end
      endcase
    end
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = advance ? res.valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r.ret_word <= RETURN_WORD_RST;
      words_r.rfi_word <= RFI_WORD_RST;
      words_r.nop_word <= NOP_WORD_RST;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      words_r     <= words_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_instr_r <= in_tdata[31:0];
      s1_base_r  <= in_tdata[63:32];
      s1_first_r <= in_tuser[0];
    end
    if (res.valid) begin
      out_bytes_r <= res.bytes;
      out_kind_r  <= res.kind;
    end
  end

  fes_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .instr (s1_instr_r),
    .first (s1_first_r),
    .base  (s1_base_r),
    .words (words_r),
    .res   (res)
  );

endmodule

[hw/rtl/fes_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_scan
// Per-word scan state and step logic: branch targets, end detection, size.
// ----------------------------------------------------------------------------
module fes_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [fes_pkg::WORD_W-1:0]    instr,
  input  logic                          first,
  input  logic [fes_pkg::WORD_W-1:0]    base,
  input  fes_pkg::words_t               words,
  output fes_pkg::result_t              res
);
  import fes_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] start_r, start_nxt;
  logic [WORD_W-1:0] ft_r, ft_nxt;

  phase_t            phase_eff;
  logic [WORD_W-1:0] cur_eff;
  logic [WORD_W-1:0] start_eff;
  logic [WORD_W-1:0] ft_eff;
  logic [WORD_W-1:0] disp;
  logic [WORD_W-1:0] target;
  logic [WORD_W-1:0] bytes;
  logic              is_branch;
  logic              is_ret;
  logic              is_rfi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      cur_r   <= '0;
      start_r <= '0;
      ft_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      start_r <= start_nxt;
      ft_r    <= ft_nxt;
    end
  end

  always_comb begin
    phase_eff = first ? PHASE_SCAN : phase_r;
    cur_eff   = first ? base : cur_r;
    start_eff = first ? base : start_r;
    ft_eff    = first ? '0 : ft_r;

    disp      = {{(WORD_W-16){instr[15]}}, instr[15:0] & DISP_MASK[15:0]};
    target    = instr[1] ? disp : cur_eff + disp;
    bytes     = cur_eff - start_eff + WORD_BYTES;
    is_branch = (instr & PRIMARY_OP_MASK) == BC_OPCODE;
    is_ret    = instr == words.ret_word;
    is_rfi    = instr == words.rfi_word;

    phase_nxt = phase_eff;
    cur_nxt   = cur_eff;
    start_nxt = start_eff;
    ft_nxt    = ft_eff;
    res.valid = 1'b0;
    res.bytes = bytes;
    res.kind  = KIND_ZERO;

    case (phase_eff)
      PHASE_AFTER_RFI: begin
        res.valid = 1'b1;
        phase_nxt = PHASE_IDLE;
        if (instr == words.nop_word) begin
          res.bytes = bytes + WORD_BYTES;
          res.kind  = KIND_RFI_NOP;
        end else begin
          res.kind  = KIND_RFI;
        end
      end
      PHASE_SCAN: begin
        if (instr != '0 && is_branch) begin
          if (ft_eff < target) begin
            ft_nxt = target;
          end
          cur_nxt = cur_eff + WORD_BYTES;
        end else if (instr != '0 && !((is_ret || is_rfi) && cur_eff >= ft_eff)) begin
          cur_nxt = cur_eff + WORD_BYTES;
        end else if (is_rfi) begin
          phase_nxt = PHASE_AFTER_RFI;
        end else begin
          res.valid = 1'b1;
          res.kind  = (instr == '0) ? KIND_ZERO : KIND_RETURN;
          phase_nxt = PHASE_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (!step) begin
      phase_nxt = phase_r;
      cur_nxt   = cur_r;
      start_nxt = start_r;
      ft_nxt    = ft_r;
      res.valid = 1'b0;
    end
  end

endmodule

[test/tb_function_extent_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_function_extent_scanner
// Self-checking bench for the function extent scanner.
//
// Instruction words stream in on in_*. A scoreboard model tracks the scan
// state and the three encodings, and queues the size and end kind of every
// function it sees finish. Each item on out_* is checked against the oldest
// queued extent. Directed cases cover branch reach, wrap, rfi tails,
// restarts and overlapping encodings. Random traffic then runs mostly whole
// functions under several encoding settings, with random stalls on both
// sides and one stretch without stalls.
// ----------------------------------------------------------------------------
module tb_function_extent_scanner;
  import fes_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [KIND_W-1:0] kind;
  } extent_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [63:0]            in_tdata   = '0;
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [31:0]            out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [WORD_W-1:0]      cfg_data   = '0;

  // scoreboard copy of the encodings and the scan state
  logic [WORD_W-1:0] ret_enc, rfi_enc, nop_enc;
  logic [WORD_W-1:0] scan_addr, func_base, reach;
  phase_t            phase;

  extent_t extent_q[$];
  int      mismatches = 0;
  int      busy_items = 0;
  bit      calm       = 1'b0;

  function_extent_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    extent_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (extent_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected extent: bytes=%h kind=%0d", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = extent_q.pop_front();
        if (out_tdata !== want.bytes || out_tuser !== want.kind) begin
          if (mismatches < 10)
            $display("extent mismatch: expected bytes=%h kind=%0d, got bytes=%h kind=%0d",
                     want.bytes, want.kind, out_tdata, out_tuser);
          mismatches++;
        end
      end
    end
  end

  task automatic reset_model();
    ret_enc   = RETURN_WORD_RST;
    rfi_enc   = RFI_WORD_RST;
    nop_enc   = NOP_WORD_RST;
    scan_addr = '0;
    func_base = '0;
    reach     = '0;
    phase     = PHASE_IDLE;
  endtask

  task automatic predict_extent(input logic [WORD_W-1:0] w, input logic first,
                                input logic [WORD_W-1:0] addr);
    logic [WORD_W-1:0] disp, tgt, size;
    if (first) begin
      func_base = addr;
      scan_addr = addr;
      reach     = '0;
      phase     = PHASE_SCAN;
    end
    size = scan_addr - func_base + WORD_BYTES;
    if (phase == PHASE_AFTER_RFI) begin
      if (w == nop_enc) extent_q.push_back('{size + WORD_BYTES, KIND_RFI_NOP});
      else extent_q.push_back('{size, KIND_RFI});
      phase = PHASE_IDLE;
    end else if (phase == PHASE_SCAN) begin
      if (w != '0 && (w & PRIMARY_OP_MASK) == BC_OPCODE) begin
        disp = w & DISP_MASK;
        if (disp[15]) disp[31:16] = '1;
        tgt = w[1] ? disp : scan_addr + disp;
        if (reach < tgt) reach = tgt;
        scan_addr += WORD_BYTES;
      end else if (w != '0 && !((w == ret_enc || w == rfi_enc) && scan_addr >= reach)) begin
        scan_addr += WORD_BYTES;
      end else if (w == rfi_enc) begin
        phase = PHASE_AFTER_RFI;
      end else begin
        extent_q.push_back('{size, (w == '0) ? KIND_ZERO : KIND_RETURN});
        phase = PHASE_IDLE;
      end
    end
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w, input logic first,
                           input logic [WORD_W-1:0] addr);
    if (!calm)
      while ($urandom_range(99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tdata  <= {addr, w};
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (first || phase != PHASE_IDLE) busy_items++;
    predict_extent(w, first, addr);
  endtask

  // hold input low until every queued extent is out and the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (extent_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RETURN_WORD: ret_enc = val;
      CFG_RFI_WORD:    rfi_enc = val;
      CFG_NOP_WORD:    nop_enc = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_base();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom & 32'h00ff_fffc;
    if (r < 85) return 32'hffff_ff00 | ($urandom & 32'h0000_00fc);
    return $urandom;
  endfunction

  function automatic logic [WORD_W-1:0] body_word();
    int r;
    logic [WORD_W-1:0] w;
    r = $urandom_range(99);
    if (r < 20)
      return BC_OPCODE | ($urandom & 32'h03ff_0000) | ($urandom_range(1, 12) * 4)
             | ($urandom & 32'h1);
    if (r < 24) return BC_OPCODE | ($urandom & 32'h03ff_ffff);
    if (r < 27) return ret_enc;
    if (r < 30) return rfi_enc;
    if (r < 34) return nop_enc;
    w = $urandom;
    if (w == '0 || (w & PRIMARY_OP_MASK) == BC_OPCODE) w ^= 32'h8000_0000;
    return w;
  endfunction

  task automatic send_function(input int body_len);
    int tries;
    int pick;
    tries = 0;
    send_word(body_word(), 1'b1, pick_base());
    for (int i = 0; i < body_len && phase == PHASE_SCAN; i++)
      send_word(body_word(), 1'b0, $urandom);
    while (phase != PHASE_IDLE) begin
      if (phase == PHASE_AFTER_RFI) begin
        send_word($urandom_range(1) ? nop_enc : $urandom, 1'b0, $urandom);
      end else if (tries < 3) begin
        tries++;
        pick = $urandom_range(2);
        send_word((pick == 0) ? ret_enc : (pick == 1) ? rfi_enc : '0, 1'b0, $urandom);
      end else begin
        send_word('0, 1'b0, $urandom);
      end
    end
  endtask

  task automatic test_return_after_branch();
    send_word(32'h4182_0008, 1'b1, 32'h0000_1000);
    send_word(RETURN_WORD_RST, 1'b0, 32'h0);
    send_word(32'h7c08_02a6, 1'b0, 32'h0);
    send_word(RETURN_WORD_RST, 1'b0, 32'h0);
  endtask

  task automatic test_idle_words();
    send_word(32'hffff_ffff, 1'b0, 32'hffff_ffff);
    send_word(RETURN_WORD_RST, 1'b0, 32'h0);
  endtask

  task automatic test_zero_wrap();
    send_word(32'h3860_0000, 1'b1, 32'hffff_fff8);
    send_word(32'h3860_0001, 1'b0, 32'h0);
    send_word(32'h0, 1'b0, 32'h0);
  endtask

  task automatic test_rfi_tails();
    send_word(RFI_WORD_RST, 1'b1, 32'h0000_2000);
    send_word(NOP_WORD_RST, 1'b0, 32'h0);
    send_word(RFI_WORD_RST, 1'b1, 32'h0000_3000);
    send_word(32'hffff_ffff, 1'b0, 32'h0);
  endtask

  task automatic test_restart();
    send_word(32'h3860_0000, 1'b1, 32'h0000_4000);
    send_word(32'h3860_0001, 1'b0, 32'h0);
    send_word(RETURN_WORD_RST, 1'b1, 32'h0000_8000);
  endtask

  task automatic test_absolute_branch();
    send_word(32'h4080_fffe, 1'b1, 32'h0);
    send_word(RETURN_WORD_RST, 1'b0, 32'h0);
    send_word(32'h0, 1'b0, 32'h0);
  endtask

  task automatic test_branch_first();
    drain();
    write_reg(CFG_RETURN_WORD, 32'h4000_0010);
    send_word(32'h4000_0010, 1'b1, 32'h0000_5000);
    send_word(32'h3860_0000, 1'b0, 32'h0);
    send_word(32'h0, 1'b0, 32'h0);
  endtask

  task automatic test_shared_encoding();
    drain();
    write_reg(CFG_RETURN_WORD, RETURN_WORD_RST);
    write_reg(CFG_RFI_WORD, RETURN_WORD_RST);
    send_word(RETURN_WORD_RST, 1'b1, 32'h0000_6000);
    send_word(NOP_WORD_RST, 1'b0, 32'h0);
  endtask

  task automatic test_zero_as_rfi();
    drain();
    write_reg(CFG_RFI_WORD, 32'h0);
    write_reg(CFG_NOP_WORD, 32'hffff_ffff);
    send_word(32'h0, 1'b1, 32'h0000_7000);
    send_word(32'hffff_ffff, 1'b0, 32'h0);
  endtask

  task automatic test_random_traffic(input logic [WORD_W-1:0] ret_v,
                                     input logic [WORD_W-1:0] rfi_v,
                                     input logic [WORD_W-1:0] nop_v,
                                     input bit quiet, input int count);
    int goal;
    int r;
    drain();
    write_reg(CFG_RETURN_WORD, ret_v);
    write_reg(CFG_RFI_WORD, rfi_v);
    write_reg(CFG_NOP_WORD, nop_v);
    calm = quiet;
    goal = busy_items + count;
    while (busy_items < goal) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_function(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10));
      end else if (r < 88) begin
        send_word(body_word(), 1'b1, pick_base());
        repeat ($urandom_range(4)) send_word(body_word(), 1'b0, $urandom);
      end else if (r < 96) begin
        send_word($urandom, 1'b0, $urandom);
      end else begin
        drain();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_return_after_branch();
    test_idle_words();
    test_zero_wrap();
    test_rfi_tails();
    test_restart();
    test_absolute_branch();
    test_branch_first();
    test_shared_encoding();
    test_zero_as_rfi();

    test_random_traffic(RETURN_WORD_RST, RFI_WORD_RST, NOP_WORD_RST, 1'b0, 110);
    test_random_traffic(RETURN_WORD_RST, RFI_WORD_RST, NOP_WORD_RST, 1'b1, 60);
    test_random_traffic(RETURN_WORD_RST, RETURN_WORD_RST, NOP_WORD_RST, 1'b0, 70);
    test_random_traffic($urandom, $urandom, $urandom, 1'b0, 70);
    test_random_traffic(32'h0, 32'h0, 32'h0, 1'b0, 70);
    test_random_traffic(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 70);
    test_random_traffic(RETURN_WORD_RST, RFI_WORD_RST, NOP_WORD_RST, 1'b0, 100);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && extent_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
